/* rtl/core/three_sensor_revolution_counter_defines.svh */
// assertion macros for the revolution counter
`ifndef THREE_SENSOR_REVOLUTION_COUNTER_DEFINES_SVH
`define THREE_SENSOR_REVOLUTION_COUNTER_DEFINES_SVH

// checked on every edge outside reset
`define TSRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TSRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tsrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsrc_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned COUNT_W  = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic [1:0] reg_index_t;

  typedef enum logic [1:0] {
    SECTOR_A = 2'd0,
    SECTOR_B = 2'd1,
    SECTOR_C = 2'd2
  } sector_t;

  typedef enum logic [1:0] {
    DIR_UNSET = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_BWD   = 2'd2
  } dir_t;

  localparam reg_index_t REG_THRESHOLD_A = 2'd0;
  localparam reg_index_t REG_THRESHOLD_B = 2'd1;
  localparam reg_index_t REG_THRESHOLD_C = 2'd2;

  localparam sample_t THRESH_RESET = 10'd120;
  localparam count_t  COUNT_MAX    = 16'sh7FFF;
  localparam count_t  COUNT_MIN    = 16'sh8000;

  typedef struct packed {
    count_t  count;
    sector_t position;
    dir_t    direction;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/three_sensor_revolution_counter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Revolution counter for three notch sensors. One input word (a sample from
// each of sensors A, B and C) is taken per clock while in_ready is high, and
// gives exactly one result word: the saturating signed revolution count, the
// current sector and the latched direction. The compare and transition logic
// is combinational between the input handshake and a two-entry output buffer
// (the result register plus one skid entry), which takes one more word while
// the output side stalls; in_ready is low while the skid entry is held.
// Thresholds are written through the cfg port (index 0, 1, 2 for sensors A,
// B, C; index 3 is ignored) and reset to 120.
`include "three_sensor_revolution_counter_defines.svh"

module three_sensor_revolution_counter (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  tsrc_pkg::reg_index_t    cfg_index,
  input  tsrc_pkg::sample_t       cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  tsrc_pkg::sample_t       sample_a,
  input  tsrc_pkg::sample_t       sample_b,
  input  tsrc_pkg::sample_t       sample_c,
  output logic                    out_valid,
  input  wire                     out_ready,
  output tsrc_pkg::count_t        revolution_count,
  output tsrc_pkg::sector_t       position,
  output tsrc_pkg::dir_t          direction
);

  import tsrc_pkg::*;

  sample_t threshold_a;
  sample_t threshold_b;
  sample_t threshold_c;

  sector_t position_reg;
  sector_t position_next;
  dir_t    direction_reg;
  dir_t    direction_next;
  count_t  count_reg;
  count_t  count_next;

  result_t out_word;
  result_t skid_word;
  logic    skid_valid;
  result_t new_word;

  logic push;
  logic pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_a <= THRESH_RESET;
      threshold_b <= THRESH_RESET;
      threshold_c <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD_A: threshold_a <= cfg_data;
        REG_THRESHOLD_B: threshold_b <= cfg_data;
        REG_THRESHOLD_C: threshold_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // sector, direction and count update
  always_comb begin
    position_next  = position_reg;
    direction_next = direction_reg;
    count_next     = count_reg;

    if (sample_a > threshold_a) begin
      position_next = SECTOR_A;
    end else if (sample_b > threshold_b) begin
      position_next = SECTOR_B;
    end else if (sample_c > threshold_c) begin
      position_next = SECTOR_C;
    end

    if (position_reg == SECTOR_A) begin
      if (position_next == SECTOR_B) begin
        direction_next = DIR_FWD;
      end else if (position_next == SECTOR_C) begin
        direction_next = DIR_BWD;
      end
    end else if (position_next == SECTOR_A) begin
      if (position_reg == SECTOR_C && direction_reg == DIR_FWD) begin
        if (count_reg != COUNT_MIN) begin
          count_next = count_reg - 16'sd1;
        end
      end else if (position_reg == SECTOR_B && direction_reg == DIR_BWD) begin
        if (count_reg != COUNT_MAX) begin
          count_next = count_reg + 16'sd1;
        end
      end
    end
  end

  assign new_word = '{count: count_next, position: position_next, direction: direction_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg  <= SECTOR_A;
      direction_reg <= DIR_UNSET;
      count_reg     <= '0;
    end else if (push) begin
      position_reg  <= position_next;
      direction_reg <= direction_next;
      count_reg     <= count_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (push) begin
        out_word <= new_word;
      end
    end else if (push) begin
      skid_word <= new_word;
    end
  end

  assign revolution_count = out_word.count;
  assign position         = out_word.position;
  assign direction        = out_word.direction;

  `TSRC_ASSERT(a_skid_behind_out, (!skid_valid || out_valid), "skid word held with empty output")
  `TSRC_ASSERT(a_count_step, (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 16'sd1 || count_reg == $past(count_reg) - 16'sd1), "count moved by more than one")
  `TSRC_ASSERT(a_dir_sticky, (direction_reg != DIR_UNSET |=> direction_reg != DIR_UNSET), "direction fell back to unset")
  `TSRC_ASSERT(a_no_count_unset, (direction_reg == DIR_UNSET |=> $stable(count_reg)), "count moved with no direction")
  `TSRC_ASSERT_ALWAYS(a_reset_clears, (rst |=> !out_valid && !skid_valid && count_reg == '0), "reset left state behind")

endmodule

`default_nettype wire

/* tb/three_sensor_revolution_counter_tb.sv */
`timescale 1ns / 1ps

module three_sensor_revolution_counter_tb;
  import tsrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int ITEMS_PER_PHASE = 225;
  localparam reg_index_t REG_UNUSED = 2'd3;
  localparam logic [1:0] NO_NOTCH = 2'd3;

  class revolution_scoreboard;
    sample_t thr_a, thr_b, thr_c;
    sector_t pos;
    dir_t dir;
    count_t cnt;
    result_t expected_q[$];
    int errors;

    function new();
      thr_a = THRESH_RESET;
      thr_b = THRESH_RESET;
      thr_c = THRESH_RESET;
      pos = SECTOR_A;
      dir = DIR_UNSET;
      cnt = '0;
      errors = 0;
    endfunction

    function void write_threshold(reg_index_t idx, sample_t val);
      case (idx)
        REG_THRESHOLD_A: thr_a = val;
        REG_THRESHOLD_B: thr_b = val;
        REG_THRESHOLD_C: thr_c = val;
        default: ;
      endcase
    endfunction

    function void note_word(sample_t a, sample_t b, sample_t c);
      sector_t prev;
      sector_t nxt;
      result_t r;
      prev = pos;
      nxt = pos;
      if (a > thr_a) nxt = SECTOR_A;
      else if (b > thr_b) nxt = SECTOR_B;
      else if (c > thr_c) nxt = SECTOR_C;
      if (prev == SECTOR_A) begin
        if (nxt == SECTOR_B) dir = DIR_FWD;
        else if (nxt == SECTOR_C) dir = DIR_BWD;
      end else if (nxt == SECTOR_A) begin
        if (prev == SECTOR_C && dir == DIR_FWD) begin
          if (cnt != COUNT_MIN) cnt = cnt - 16'sd1;
        end else if (prev == SECTOR_B && dir == DIR_BWD) begin
          if (cnt != COUNT_MAX) cnt = cnt + 16'sd1;
        end
      end
      pos = nxt;
      r.count = cnt;
      r.position = pos;
      r.direction = dir;
      expected_q.push_back(r);
    endfunction

    function void check_result(count_t c, sector_t p, dir_t d);
      result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: revolution_count %0d", c);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (c !== r.count) begin
        $error("revolution_count: expected %0d, got %0d", r.count, c);
        errors++;
      end
      if (p !== r.position) begin
        $error("position: expected %0d, got %0d", r.position, p);
        errors++;
      end
      if (d !== r.direction) begin
        $error("direction: expected %0d, got %0d", r.direction, d);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  reg_index_t cfg_index;
  sample_t cfg_data;
  logic in_valid;
  logic in_ready;
  sample_t sample_a, sample_b, sample_c;
  logic out_valid;
  logic out_ready = 1'b0;
  count_t revolution_count;
  sector_t position;
  dir_t direction;

  revolution_scoreboard sb;
  sample_t cur_thr[3];
  bit gaps_on;
  int burst_left;
  int stall_pct = 0;
  int stall_max = 1;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  logic [1:0] walk_pos;
  bit walk_fwd;

  three_sensor_revolution_counter u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_a(sample_a),
    .sample_b(sample_b),
    .sample_c(sample_c),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .revolution_count(revolution_count),
    .position(position),
    .direction(direction)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(stall_max - 1, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_threshold(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_word(sample_a, sample_b, sample_c);
      if (out_valid && out_ready) sb.check_result(revolution_count, position, direction);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic pace_send(input sample_t a, input sample_t b, input sample_t c);
    in_valid <= 1'b1;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    do @(posedge clk); while (!in_ready);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
        burst_left = $urandom_range(20, 1);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_thresholds(input sample_t th_a, input sample_t th_b, input sample_t th_c);
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= sample_t'($urandom);
    @(posedge clk);
    cfg_index <= REG_THRESHOLD_A;
    cfg_data <= th_a;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD_B;
    cfg_data <= th_b;
    @(posedge clk);
    cfg_index <= REG_THRESHOLD_C;
    cfg_data <= th_c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_thr[REG_THRESHOLD_A] = th_a;
    cur_thr[REG_THRESHOLD_B] = th_b;
    cur_thr[REG_THRESHOLD_C] = th_c;
  endtask

  function automatic sample_t pick_sample(sample_t thr, bit notch);
    if (notch && int'(thr) != SAMPLE_MAX)
      return sample_t'($urandom_range(SAMPLE_MAX, int'(thr) + 1));
    return sample_t'($urandom_range(int'(thr), 0));
  endfunction

  function automatic logic [1:0] next_sector(logic [1:0] p, bit fwd);
    if (fwd) return (p == SECTOR_C) ? SECTOR_A : p + 2'd1;
    return (p == SECTOR_A) ? SECTOR_C : p - 2'd1;
  endfunction

  // lower-priority sensors may report as well
  task automatic send_sector(input logic [1:0] target);
    bit na, nb, nc;
    na = (target == SECTOR_A);
    nb = (target == SECTOR_B) || (target == SECTOR_A && $urandom_range(1));
    nc = (target == SECTOR_C) || (target != NO_NOTCH && $urandom_range(1));
    pace_send(pick_sample(cur_thr[REG_THRESHOLD_A], na),
              pick_sample(cur_thr[REG_THRESHOLD_B], nb),
              pick_sample(cur_thr[REG_THRESHOLD_C], nc));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      walk_pos = next_sector(walk_pos, walk_fwd);
      send_sector(walk_pos);
    end else if (r < 68) begin
      send_sector(walk_pos);
    end else if (r < 78) begin
      send_sector(NO_NOTCH);
    end else if (r < 86) begin
      walk_fwd = !walk_fwd;
      walk_pos = next_sector(walk_pos, walk_fwd);
      send_sector(walk_pos);
    end else begin
      pace_send(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
    end
  endtask

  task automatic run_phase(input sample_t th_a, input sample_t th_b, input sample_t th_c,
                           input bit gaps, input int pct, input int smax);
    set_thresholds(th_a, th_b, th_c);
    gaps_on = gaps;
    burst_left = $urandom_range(20, 1);
    stall_pct <= pct;
    stall_max <= smax;
    repeat (ITEMS_PER_PHASE) random_item();
    drain();
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_THRESHOLD_A;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample_a <= '0;
    sample_b <= '0;
    sample_c <= '0;
    cur_thr[REG_THRESHOLD_A] = THRESH_RESET;
    cur_thr[REG_THRESHOLD_B] = THRESH_RESET;
    cur_thr[REG_THRESHOLD_C] = THRESH_RESET;
    gaps_on = 1'b0;
    burst_left = 1;
    walk_pos = SECTOR_A;
    walk_fwd = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds: priority, strict compare, direction latching
    pace_send(10'd0, 10'd0, 10'd0);
    pace_send(10'd1023, 10'd1023, 10'd1023);
    pace_send(10'd121, 10'd0, 10'd0);
    pace_send(10'd120, 10'd121, 10'd0);
    pace_send(10'd0, 10'd0, 10'd121);
    pace_send(10'd121, 10'd0, 10'd0);
    pace_send(10'd0, 10'd0, 10'd0);
    pace_send(10'd0, 10'd0, 10'd1023);
    pace_send(10'd0, 10'd1023, 10'd1023);
    pace_send(10'd1023, 10'd0, 10'd0);
    pace_send(10'd120, 10'd120, 10'd120);
    pace_send(10'd0, 10'd500, 10'd0);
    pace_send(10'd500, 10'd0, 10'd0);
    pace_send(10'd0, 10'd0, 10'd500);
    pace_send(10'd500, 10'd0, 10'd0);
    drain();

    // top threshold: no sensor can report
    set_thresholds(10'd1023, 10'd1023, 10'd1023);
    pace_send(10'd1023, 10'd1023, 10'd1023);
    drain();

    set_thresholds(10'd0, 10'd0, 10'd0);
    pace_send(10'd0, 10'd0, 10'd0);
    pace_send(10'd1, 10'd0, 10'd0);
    pace_send(10'd0, 10'd1, 10'd0);
    pace_send(10'd0, 10'd0, 10'd1);
    pace_send(10'd1, 10'd1, 10'd1);
    drain();
    walk_pos = SECTOR_A;

    run_phase(THRESH_RESET, THRESH_RESET, THRESH_RESET, 1'b1, 20, 4);
    run_phase(10'd0, 10'd0, 10'd0, 1'b0, 0, 1);
    run_phase(10'd1023, sample_t'($urandom), sample_t'($urandom), 1'b1, 40, 8);
    run_phase(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom), 1'b1, 10, 2);
    run_phase(sample_t'($urandom), 10'd1023, 10'd0, 1'b0, 30, 6);
    run_phase(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom), 1'b1, 25, 12);

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
